// ===== design/grid_broadphase_pairs_2d_assert.svh =====
// ----------------------------------------------------------------------------
// Grid broadphase assertion macros
// Implication and next-cycle checks, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef GRID_BROADPHASE_PAIRS_2D_ASSERT_SVH
`define GRID_BROADPHASE_PAIRS_2D_ASSERT_SVH

`ifndef SYNTH
`define GBP_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("gbp: same-cycle check failed");
`define GBP_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("gbp: next-cycle check failed");
`else
`define GBP_ASSERT_IMP(lbl, a, c)
`define GBP_ASSERT_NXT(lbl, a, c)
`endif

`endif

// ===== design/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared types and codes of the 2D grid broadphase.
// ----------------------------------------------------------------------------
`default_nettype none

package gbp_pkg;

  localparam int INDEX_W = 6;

  // shape kinds
  localparam logic [2:0] KIND_POINT   = 3'd0;
  localparam logic [2:0] KIND_CIRCLE  = 3'd1;
  localparam logic [2:0] KIND_RECT    = 3'd2;
  localparam logic [2:0] KIND_SEGMENT = 3'd3;
  localparam logic [2:0] KIND_CAPSULE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CELL_SHIFT = 2'd0;
  localparam logic [1:0] CFG_MAX_CELLS  = 2'd1;

  localparam logic [4:0]  CELL_SHIFT_RESET = 5'd12;
  localparam logic [15:0] MAX_CELLS_RESET  = 16'd256;

  localparam int ITEM_Q_DEPTH = 4;
  localparam int PAIR_Q_DEPTH = 2;

  typedef struct packed {
    logic [4:0]  cell_shift;
    logic [15:0] max_cells;
  } gbp_cfg_t;

  typedef struct packed {
    logic frame_start;
    logic enabled;
    logic is_glob;
  } gbp_flags_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_low;
    logic [INDEX_W-1:0] index_high;
    logic               last;
  } gbp_pair_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_BOX,
    F_CELL,
    F_SPAN,
    F_CHECK,
    F_PUSH
  } gbp_front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_FLUSH
  } gbp_back_state_t;

endpackage

`default_nettype wire

// ===== design/gbp_fifo.sv =====
// ----------------------------------------------------------------------------
// gbp_fifo
// Small register queue with push/full and pop/empty, head shown while not empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gbp_front.sv =====
// ----------------------------------------------------------------------------
// gbp_front
// Takes collider items, assigns indexes, builds the cell rectangle and
// global flag, and queues the classified item for the pair scan.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_front
  import gbp_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int COORD_BITS    = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gbp_cfg_t              cfg,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  frame_start,
  input  wire logic                  enabled,
  input  wire logic [2:0]            shape_kind,
  input  wire logic [COORD_BITS-1:0] coord_x0,
  input  wire logic [COORD_BITS-1:0] coord_y0,
  input  wire logic [COORD_BITS-1:0] coord_x1,
  input  wire logic [COORD_BITS-1:0] coord_y1,
  input  wire logic [COORD_BITS-2:0] radius,
  output logic                       q_push,
  output logic [$clog2(MAX_COLLIDERS)+3+4*COORD_BITS-1:0] q_data,
  input  wire logic                  q_full
);

  localparam int C     = COORD_BITS;
  localparam int IW    = $clog2(MAX_COLLIDERS);
  localparam int CNT_W = IW + 1;
  localparam int BW    = C + 1;
  localparam int SW    = (C + 3 > 17) ? C + 3 : 17;

  gbp_front_state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_eff;
  logic             accept;
  logic             drop;

  logic          fs, en;
  logic [2:0]    kind;
  logic [C-1:0]  x0, y0, x1, y1;
  logic [C-2:0]  r;
  logic [IW-1:0] cur;

  logic [BW-1:0] bx0, by0, bx1, by1;
  logic          kglob;
  logic [BW-1:0] bx0_c, by0_c, bx1_c, by1_c;
  logic          kglob_c;

  logic [BW-1:0] mnx, mny, mxx, mxy;
  logic [SW-1:0] cx, cy;
  logic          span_bad;
  logic [31:0]   prod;
  logic [C-1:0]  cminx, cminy, cmaxx, cmaxy;
  logic          glob;
  gbp_flags_t    flags;

  assign accept    = push && !full;
  assign count_eff = frame_start ? '0 : count;
  assign drop      = (count_eff == CNT_W'(MAX_COLLIDERS));

  // bounding box of the shape, exact in one extra bit
  always_comb begin
    logic [BW-1:0] x0e, y0e, x1e, y1e, re, cap, lox, loy, hix, hiy;
    x0e = {x0[C-1], x0};
    y0e = {y0[C-1], y0};
    x1e = {x1[C-1], x1};
    y1e = {y1[C-1], y1};
    re  = {2'b00, r};
    cap = (kind == KIND_CAPSULE) ? re : '0;
    lox = ($signed(x0e) < $signed(x1e)) ? x0e : x1e;
    hix = ($signed(x0e) < $signed(x1e)) ? x1e : x0e;
    loy = ($signed(y0e) < $signed(y1e)) ? y0e : y1e;
    hiy = ($signed(y0e) < $signed(y1e)) ? y1e : y0e;
    kglob_c = 1'b0;
    bx0_c = x0e;
    by0_c = y0e;
    bx1_c = x0e;
    by1_c = y0e;
    case (kind)
      KIND_POINT: begin
      end
      KIND_CIRCLE: begin
        bx0_c = x0e - re;
        by0_c = y0e - re;
        bx1_c = x0e + re;
        by1_c = y0e + re;
      end
      KIND_RECT: begin
        bx0_c = x0e - x1e;
        by0_c = y0e - y1e;
        bx1_c = x0e + x1e;
        by1_c = y0e + y1e;
      end
      KIND_SEGMENT, KIND_CAPSULE: begin
        bx0_c = lox - cap;
        by0_c = loy - cap;
        bx1_c = hix + cap;
        by1_c = hiy + cap;
      end
      default: begin
        kglob_c = 1'b1;
      end
    endcase
  end

  function automatic logic [C-1:0] sat_cell(input logic [BW-1:0] v);
    if (v[BW-1] != v[BW-2]) begin
      sat_cell = {v[BW-1], {(C-1){~v[BW-1]}}};
    end else begin
      sat_cell = v[C-1:0];
    end
  endfunction

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept && !drop) begin
          state_next = enabled ? F_BOX : F_PUSH;
        end
      end
      F_BOX:   state_next = F_CELL;
      F_CELL:  state_next = F_SPAN;
      F_SPAN:  state_next = F_CHECK;
      F_CHECK: state_next = F_PUSH;
      F_PUSH: begin
        if (!q_full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full   = 1'b1;
    q_push = 1'b0;
    case (state)
      F_IDLE:  full = 1'b0;
      F_PUSH:  q_push = !q_full;
      default: begin
      end
    endcase
  end

  assign glob  = kglob || span_bad || (prod > {16'd0, cfg.max_cells});
  assign flags = '{frame_start: fs, enabled: en, is_glob: glob};
  assign q_data = {flags, cur, cminx, cminy, cmaxx, cmaxy};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= drop ? count_eff : count_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        fs   <= frame_start;
        en   <= enabled;
        kind <= shape_kind;
        x0   <= coord_x0;
        y0   <= coord_y0;
        x1   <= coord_x1;
        y1   <= coord_y1;
        r    <= radius;
        cur  <= count_eff[IW-1:0];
      end
      F_BOX: begin
        bx0   <= bx0_c;
        by0   <= by0_c;
        bx1   <= bx1_c;
        by1   <= by1_c;
        kglob <= kglob_c;
      end
      F_CELL: begin
        // arithmetic shift is floor division by the cell size
        mnx <= $signed(bx0) >>> cfg.cell_shift;
        mny <= $signed(by0) >>> cfg.cell_shift;
        mxx <= $signed(bx1) >>> cfg.cell_shift;
        mxy <= $signed(by1) >>> cfg.cell_shift;
      end
      F_SPAN: begin
        cx <= {{(SW-BW){mxx[BW-1]}}, mxx} - {{(SW-BW){mnx[BW-1]}}, mnx} + SW'(1);
        cy <= {{(SW-BW){mxy[BW-1]}}, mxy} - {{(SW-BW){mny[BW-1]}}, mny} + SW'(1);
      end
      F_CHECK: begin
        // spans are checked on the unsaturated cell bounds
        span_bad <= cx[SW-1] || (cx == '0) || cy[SW-1] || (cy == '0) ||
                    (cx > {{(SW-16){1'b0}}, cfg.max_cells}) ||
                    (cy > {{(SW-16){1'b0}}, cfg.max_cells});
        prod  <= cx[15:0] * cy[15:0];
        cminx <= sat_cell(mnx);
        cminy <= sat_cell(mny);
        cmaxx <= sat_cell(mxx);
        cmaxy <= sat_cell(mxy);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/gbp_back.sv =====
// ----------------------------------------------------------------------------
// gbp_back
// Stores classified colliders and scans earlier entries, one per cycle unless
// stalled by a full output, emitting candidate pairs in ascending index order.
// ----------------------------------------------------------------------------
`default_nettype none

module gbp_back
  import gbp_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int COORD_BITS    = 24
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire logic [$clog2(MAX_COLLIDERS)+3+4*COORD_BITS-1:0] q_data,
  output logic            q_pop,
  output logic            out_push,
  output gbp_pair_t       out_item,
  input  wire logic       out_full
);

  localparam int C  = COORD_BITS;
  localparam int IW = $clog2(MAX_COLLIDERS);
  localparam int QW = IW + 3 + 4 * C;
  localparam int FW = $bits(gbp_flags_t);
  localparam int EW = 1 + 4 * C;

  gbp_back_state_t state, state_next;

  gbp_flags_t    q_flags;
  logic [IW-1:0] q_cur;
  logic [4*C-1:0] q_rect;

  logic [EW-1:0]  mem [MAX_COLLIDERS];
  logic [EW-1:0]  rdata;
  logic [IW-1:0]  rd_addr;

  logic [MAX_COLLIDERS-1:0] active;
  logic [IW-1:0]  cur;
  logic           cur_glob;
  logic [C-1:0]   cminx, cminy, cmaxx, cmaxy;
  logic [IW-1:0]  cmp_j;
  logic           pend_valid;
  logic [IW-1:0]  pend_j;

  logic           r_glob;
  logic [C-1:0]   rminx, rminy, rmaxx, rmaxy;
  logic           hit;
  logic           scan_end;
  logic           adv;

  assign q_flags = gbp_flags_t'(q_data[QW-1 -: FW]);
  assign q_cur   = q_data[4*C +: IW];
  assign q_rect  = q_data[4*C-1:0];

  assign {r_glob, rminx, rminy, rmaxx, rmaxy} = rdata;

  assign hit = active[cmp_j] && (cur_glob || r_glob ||
               ($signed(rminx) <= $signed(cmaxx) && $signed(cminx) <= $signed(rmaxx) &&
                $signed(rminy) <= $signed(cmaxy) && $signed(cminy) <= $signed(rmaxy)));
  assign scan_end = (cmp_j == cur - 1'b1);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && q_flags.enabled && (q_cur != '0)) begin
          state_next = B_SCAN;
        end
      end
      B_SCAN: begin
        if (adv && scan_end) begin
          state_next = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (!pend_valid || !out_full) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // a hit is held back one step so the final pair of an item can carry last
  always_comb begin
    q_pop    = 1'b0;
    out_push = 1'b0;
    adv      = 1'b0;
    out_item = '{index_low: INDEX_W'(pend_j), index_high: INDEX_W'(cur), last: 1'b0};
    case (state)
      B_IDLE: begin
        q_pop = !q_empty;
      end
      B_SCAN: begin
        adv      = !(hit && pend_valid && out_full);
        out_push = hit && pend_valid && !out_full;
      end
      B_FLUSH: begin
        out_push      = pend_valid && !out_full;
        out_item.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // on a stall the same entry is read again
  assign rd_addr = (state == B_IDLE) ? '0 : (adv ? cmp_j + 1'b1 : cmp_j);

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (q_pop && q_flags.enabled) begin
      mem[q_cur] <= {q_flags.is_glob, q_rect};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      active     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        logic [MAX_COLLIDERS-1:0] act_next;
        act_next = q_flags.frame_start ? '0 : active;
        act_next[q_cur] = q_flags.enabled;
        active     <= act_next;
        pend_valid <= 1'b0;
      end else if (state == B_SCAN && adv && hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_cur;
      cur_glob <= q_flags.is_glob;
      {cminx, cminy, cmaxx, cmaxy} <= q_rect;
      cmp_j    <= '0;
    end else if (state == B_SCAN && adv) begin
      cmp_j <= cmp_j + 1'b1;
      if (hit) begin
        pend_j <= cmp_j;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/grid_broadphase_pairs_2d.sv =====
// ----------------------------------------------------------------------------
// grid_broadphase_pairs_2d
// 2D uniform-grid broadphase: classifies colliders into cell rectangles and
// emits candidate pairs against the stored colliders of the frame.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     push / full           frame_start enabled shape_kind coord_* radius
//  result    pop / empty           index_low index_high last
//  config    cfg_valid / cfg_ready cfg_index cfg_data
//
//  Front: enabled items pass box, cell, span, check and push; disabled items
//  go straight to push, dropped items are not queued. Back: one stored entry
//  compared per cycle unless stalled, via the entry memory's single read port.
//  Reset clears the valid bits of all entries at once; no clearing pass.
//  A full result queue stalls the scan; the item queue lets the front run ahead.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_broadphase_pairs_2d
  import gbp_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int COORD_BITS    = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  frame_start,
  input  wire logic                  enabled,
  input  wire logic [2:0]            shape_kind,
  input  wire logic [COORD_BITS-1:0] coord_x0,
  input  wire logic [COORD_BITS-1:0] coord_y0,
  input  wire logic [COORD_BITS-1:0] coord_x1,
  input  wire logic [COORD_BITS-1:0] coord_y1,
  input  wire logic [COORD_BITS-2:0] radius,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [INDEX_W-1:0]         index_low,
  output logic [INDEX_W-1:0]         index_high,
  output logic                       last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

`include "grid_broadphase_pairs_2d_assert.svh"

  localparam int QW = $clog2(MAX_COLLIDERS) + 3 + 4 * COORD_BITS;

  gbp_cfg_t    cfg;
  logic        item_push, item_full, item_pop, item_empty;
  logic [QW-1:0] item_wdata, item_rdata;
  logic        pair_push, pair_full;
  gbp_pair_t   pair_wdata, pair_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_shift <= CELL_SHIFT_RESET;
      cfg.max_cells  <= MAX_CELLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CELL_SHIFT: cfg.cell_shift <= cfg_data[4:0];
        CFG_MAX_CELLS:  cfg.max_cells  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gbp_front #(
    .MAX_COLLIDERS (MAX_COLLIDERS),
    .COORD_BITS    (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .frame_start (frame_start),
    .enabled     (enabled),
    .shape_kind  (shape_kind),
    .coord_x0    (coord_x0),
    .coord_y0    (coord_y0),
    .coord_x1    (coord_x1),
    .coord_y1    (coord_y1),
    .radius      (radius),
    .q_push      (item_push),
    .q_data      (item_wdata),
    .q_full      (item_full)
  );

  gbp_fifo #(
    .WIDTH (QW),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (item_push),
    .wdata (item_wdata),
    .full  (item_full),
    .pop   (item_pop),
    .rdata (item_rdata),
    .empty (item_empty)
  );

  gbp_back #(
    .MAX_COLLIDERS (MAX_COLLIDERS),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (item_empty),
    .q_data   (item_rdata),
    .q_pop    (item_pop),
    .out_push (pair_push),
    .out_item (pair_wdata),
    .out_full (pair_full)
  );

  gbp_fifo #(
    .WIDTH ($bits(gbp_pair_t)),
    .DEPTH (PAIR_Q_DEPTH)
  ) u_pair_q (
    .clk   (clk),
    .rst   (rst),
    .push  (pair_push),
    .wdata (pair_wdata),
    .full  (pair_full),
    .pop   (pop),
    .rdata (pair_rdata),
    .empty (empty)
  );

  assign index_low  = pair_rdata.index_low;
  assign index_high = pair_rdata.index_high;
  assign last       = pair_rdata.last;

  `GBP_ASSERT_IMP(a_item_push_room, item_push, !item_full)
  `GBP_ASSERT_IMP(a_pair_push_room, pair_push, !pair_full)
  `GBP_ASSERT_IMP(a_pair_order, !empty, index_low < index_high)
  `GBP_ASSERT_NXT(a_cfg_shift, cfg_valid && cfg_ready && cfg_index == CFG_CELL_SHIFT, cfg.cell_shift == $past(cfg_data[4:0]))

endmodule

`default_nettype wire

// ===== sim/grid_broadphase_pairs_2d_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_broadphase_pairs_2d_checker
// Watches the collider, pair and register channels of the broadphase, keeps
// its own copy of the frame's stored colliders, predicts the candidate pairs
// of every accepted collider and compares each popped pair in order.
// ----------------------------------------------------------------------------

module grid_broadphase_pairs_2d_checker
  import gbp_pkg::*;
#(
  parameter int MAX_COLLIDERS = 64,
  parameter int COORD_BITS    = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire logic                  full,
  input  wire logic                  frame_start,
  input  wire logic                  enabled,
  input  wire logic [2:0]            shape_kind,
  input  wire logic [COORD_BITS-1:0] coord_x0,
  input  wire logic [COORD_BITS-1:0] coord_y0,
  input  wire logic [COORD_BITS-1:0] coord_x1,
  input  wire logic [COORD_BITS-1:0] coord_y1,
  input  wire logic [COORD_BITS-2:0] radius,
  input  wire logic                  empty,
  input  wire logic                  pop,
  input  wire logic [INDEX_W-1:0]    index_low,
  input  wire logic [INDEX_W-1:0]    index_high,
  input  wire logic                  last,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  output int                         fail_count,
  output int                         pairs_pending,
  output int                         pairs_checked,
  output int                         globals_seen,
  output int                         items_dropped
);

  localparam int MAX_REPORTS = 20;

  logic [4:0]  grid_shift;
  logic [15:0] cell_limit;

  longint cell_lo_x [MAX_COLLIDERS];
  longint cell_lo_y [MAX_COLLIDERS];
  longint cell_hi_x [MAX_COLLIDERS];
  longint cell_hi_y [MAX_COLLIDERS];
  bit     is_global [MAX_COLLIDERS];
  bit     is_live   [MAX_COLLIDERS];
  int     next_slot;

  gbp_pair_t expected_pairs[$];

  // stored cell bounds clip to the signed coordinate range
  function automatic longint clip_cell(input longint c);
    longint hi;
    longint lo;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (c > hi) return hi;
    if (c < lo) return lo;
    return c;
  endfunction

  task automatic predict_pairs();
    longint x0, y0, x1, y1, r;
    longint bx0, by0, bx1, by1;
    longint mnx, mny, mxx, mxy, cx, cy, lim;
    bit     glob;
    int     cur;
    int     hits;
    gbp_pair_t p;

    if (frame_start) begin
      foreach (is_live[i]) is_live[i] = 1'b0;
      next_slot = 0;
    end
    if (next_slot >= MAX_COLLIDERS) begin
      items_dropped++;
      return;
    end
    cur = next_slot;
    next_slot++;
    is_live[cur] = enabled;
    if (!enabled) return;

    x0 = $signed(coord_x0);
    y0 = $signed(coord_y0);
    x1 = $signed(coord_x1);
    y1 = $signed(coord_y1);
    r = radius;
    bx0 = 0; by0 = 0; bx1 = 0; by1 = 0;
    glob = 1'b0;

    case (shape_kind)
      KIND_POINT: begin
        bx0 = x0; by0 = y0; bx1 = x0; by1 = y0;
      end
      KIND_CIRCLE: begin
        bx0 = x0 - r; by0 = y0 - r; bx1 = x0 + r; by1 = y0 + r;
      end
      KIND_RECT: begin
        bx0 = x0 - x1; by0 = y0 - y1; bx1 = x0 + x1; by1 = y0 + y1;
      end
      KIND_SEGMENT, KIND_CAPSULE: begin
        bx0 = (x0 < x1) ? x0 : x1;
        by0 = (y0 < y1) ? y0 : y1;
        bx1 = (x0 > x1) ? x0 : x1;
        by1 = (y0 > y1) ? y0 : y1;
        if (shape_kind == KIND_CAPSULE) begin
          bx0 -= r; by0 -= r; bx1 += r; by1 += r;
        end
      end
      default: glob = 1'b1;
    endcase

    cell_lo_x[cur] = 0; cell_lo_y[cur] = 0;
    cell_hi_x[cur] = 0; cell_hi_y[cur] = 0;
    if (!glob) begin
      // arithmetic shift floors toward minus infinity
      mnx = bx0 >>> grid_shift;
      mny = by0 >>> grid_shift;
      mxx = bx1 >>> grid_shift;
      mxy = by1 >>> grid_shift;
      cx = mxx - mnx + 1;
      cy = mxy - mny + 1;
      lim = cell_limit;
      if (cx <= 0 || cy <= 0 || cx > lim || cy > lim || cx * cy > lim) begin
        glob = 1'b1;
      end else begin
        cell_lo_x[cur] = clip_cell(mnx);
        cell_lo_y[cur] = clip_cell(mny);
        cell_hi_x[cur] = clip_cell(mxx);
        cell_hi_y[cur] = clip_cell(mxy);
      end
    end
    is_global[cur] = glob;
    if (glob) globals_seen++;

    hits = 0;
    for (int j = 0; j < cur; j++) begin
      if (is_live[j] && (glob || is_global[j] ||
          (cell_lo_x[j] <= cell_hi_x[cur] && cell_lo_x[cur] <= cell_hi_x[j] &&
           cell_lo_y[j] <= cell_hi_y[cur] && cell_lo_y[cur] <= cell_hi_y[j]))) begin
        p.index_low  = INDEX_W'(j);
        p.index_high = INDEX_W'(cur);
        p.last       = 1'b0;
        expected_pairs.insert(expected_pairs.size(), p);
        hits++;
      end
    end
    if (hits > 0) expected_pairs[expected_pairs.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk) begin
    gbp_pair_t want;
    if (rst) begin
      grid_shift = CELL_SHIFT_RESET;
      cell_limit = MAX_CELLS_RESET;
      foreach (is_live[i]) is_live[i] = 1'b0;
      next_slot = 0;
      expected_pairs.delete();
      fail_count = 0;
      pairs_checked = 0;
      globals_seen = 0;
      items_dropped = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CELL_SHIFT) grid_shift = cfg_data[4:0];
        else if (cfg_index == CFG_MAX_CELLS) cell_limit = cfg_data;
      end

      if (pop && !empty) begin
        if (expected_pairs.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: expected no pair, got low=%0d high=%0d last=%0b", $time,
                     index_low, index_high, last);
        end else begin
          want = expected_pairs.pop_front();
          pairs_checked++;
          if (want.index_low !== index_low || want.index_high !== index_high ||
              want.last !== last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: pair mismatch: expected %0d,%0d,%0b got %0d,%0d,%0b",
                       $time, want.index_low, want.index_high, want.last,
                       index_low, index_high, last);
          end
        end
      end

      if (push && !full) predict_pairs();
    end
    pairs_pending = expected_pairs.size();
  end

endmodule

// ===== sim/grid_broadphase_pairs_2d_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_broadphase_pairs_2d_tb
// Drives directed and random colliders through the broadphase across several
// grid settings, with random gaps on the collider side and random stalls on
// the pair side; the checker beside the block predicts and compares pairs.
// ----------------------------------------------------------------------------

module grid_broadphase_pairs_2d_tb;
  import gbp_pkg::*;

  localparam int COORD_BITS  = 24;
  localparam int SETTLE      = 800;
  localparam int IDLE_LIMIT  = 5000;

  // kinds with no name in the package: all of them are global
  localparam logic [2:0] KIND_OTHER = 3'd5;
  localparam logic [2:0] KIND_RSVD6 = 3'd6;
  localparam logic [2:0] KIND_RSVD7 = 3'd7;

  typedef struct {
    bit                  frame_start;
    bit                  enabled;
    logic [2:0]          kind;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [COORD_BITS-2:0] r;
  } collider_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic frame_start = 1'b0;
  logic enabled = 1'b0;
  logic [2:0] shape_kind = '0;
  logic [COORD_BITS-1:0] coord_x0 = '0;
  logic [COORD_BITS-1:0] coord_y0 = '0;
  logic [COORD_BITS-1:0] coord_x1 = '0;
  logic [COORD_BITS-1:0] coord_y1 = '0;
  logic [COORD_BITS-2:0] radius = '0;
  logic empty;
  logic pop = 1'b0;
  logic [INDEX_W-1:0] index_low;
  logic [INDEX_W-1:0] index_high;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int fail_count;
  int pairs_pending;
  int pairs_checked;
  int globals_seen;
  int items_dropped;

  int  cur_shift = CELL_SHIFT_RESET;
  int  items_sent = 0;
  int  settings_used = 0;
  bit  send_calm = 1'b0;
  bit  pop_calm = 1'b0;
  int  pop_hold = 0;
  int  pop_roll;
  int  idle_cycles = 0;

  always #5 clk = ~clk;

  grid_broadphase_pairs_2d u_top (.*);

  grid_broadphase_pairs_2d_checker u_checker (.*);

  // pair side: short stalls mostly, a few long ones, calm stretches with none
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 199) == 0) pop_calm = !pop_calm;
      if (!pop_calm) begin
        pop_roll = $urandom_range(0, 99);
        if (pop_roll < 20) pop_hold = $urandom_range(1, 3);
        else if (pop_roll < 23) pop_hold = $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL grid_broadphase_pairs_2d");
        $finish;
      end
    end
  end

  function automatic collider_t collider(input bit fs, input bit en, input logic [2:0] k,
                                         input int x0, input int y0, input int x1,
                                         input int y1, input int r);
    collider_t c;
    c.frame_start = fs;
    c.enabled = en;
    c.kind = k;
    c.x0 = x0[COORD_BITS-1:0];
    c.y0 = y0[COORD_BITS-1:0];
    c.x1 = x1[COORD_BITS-1:0];
    c.y1 = y1[COORD_BITS-1:0];
    c.r = r[COORD_BITS-2:0];
    return c;
  endfunction

  // shapes clustered within a few cells of the origin; some wild values
  function automatic collider_t random_collider(input int spread);
    collider_t c;
    int unit, span, roll, hx, hy;
    unit = 1 << ((cur_shift > 18) ? 18 : cur_shift);
    span = unit * spread;
    c.frame_start = 1'b0;
    c.enabled = ($urandom_range(0, 9) != 0);
    roll = $urandom_range(0, 99);
    if (roll < 18) c.kind = KIND_POINT;
    else if (roll < 36) c.kind = KIND_CIRCLE;
    else if (roll < 56) c.kind = KIND_RECT;
    else if (roll < 74) c.kind = KIND_SEGMENT;
    else if (roll < 94) c.kind = KIND_CAPSULE;
    else c.kind = 3'($urandom_range(KIND_OTHER, KIND_RSVD7));
    if ($urandom_range(0, 9) == 0) begin
      c.x0 = COORD_BITS'($urandom);
      c.y0 = COORD_BITS'($urandom);
      c.x1 = COORD_BITS'($urandom);
      c.y1 = COORD_BITS'($urandom);
      c.r = (COORD_BITS-1)'($urandom);
    end else begin
      c.x0 = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      c.y0 = COORD_BITS'(int'($urandom_range(0, 2 * span)) - span);
      if (c.kind == KIND_RECT) begin
        hx = $urandom_range(0, 2 * unit);
        hy = $urandom_range(0, 2 * unit);
        if ($urandom_range(0, 15) == 0) hx = -int'($urandom_range(1, unit));
        if ($urandom_range(0, 15) == 0) hy = -int'($urandom_range(1, unit));
        c.x1 = COORD_BITS'(hx);
        c.y1 = COORD_BITS'(hy);
      end else begin
        c.x1 = c.x0 + COORD_BITS'(int'($urandom_range(0, 2 * unit)) - unit);
        c.y1 = c.y0 + COORD_BITS'(int'($urandom_range(0, 2 * unit)) - unit);
      end
      c.r = (COORD_BITS-1)'($urandom_range(0, unit));
    end
    return c;
  endfunction

  // called and returns at a falling edge
  task automatic send_item(input collider_t c);
    int gap, roll;
    if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
    roll = $urandom_range(0, 99);
    if (send_calm || roll < 50) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    frame_start <= c.frame_start;
    enabled <= c.enabled;
    shape_kind <= c.kind;
    coord_x0 <= c.x0;
    coord_y0 <= c.y0;
    coord_x1 <= c.x1;
    coord_y1 <= c.y1;
    radius <= c.r;
    push <= 1'b1;
    do @(posedge clk); while (full);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait (pairs_pending == 0);
    // items without pairs may still be in flight
    repeat (SETTLE) @(negedge clk);
  endtask

  // leaves valid high; the caller drops it after its last write
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_config(input int shift, input int cells);
    cfg_write(CFG_CELL_SHIFT, 16'(shift));
    cfg_write(CFG_MAX_CELLS, 16'(cells));
    cfg_valid <= 1'b0;
    cur_shift = shift;
    settings_used++;
  endtask

  // fill_frame: first 64 enabled, the 64th global, the rest dropped
  task automatic run_frame(input int n, input int spread, input bit fill_frame);
    collider_t c;
    for (int i = 0; i < n; i++) begin
      c = random_collider(spread);
      c.frame_start = (i == 0) || (!fill_frame && $urandom_range(0, 32) == 0);
      if (fill_frame && i < 64) c.enabled = 1'b1;
      if (fill_frame && i == 63) c.kind = KIND_RSVD7;
      send_item(c);
    end
  endtask

  initial begin
    int left, n;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed colliders with reset settings: 4096-unit cells, 256-cell limit
    send_item(collider(1, 1, KIND_POINT, 0, 0, 0, 0, 0));
    send_item(collider(0, 1, KIND_POINT, -1, -1, 0, 0, 0));
    send_item(collider(0, 1, KIND_CIRCLE, 0, 0, 0, 0, 1));
    send_item(collider(0, 1, KIND_RECT, 100, 100, -5, 3, 0));
    send_item(collider(0, 1, KIND_RECT, 0, 0, 32767, 32767, 0));
    send_item(collider(0, 1, KIND_RECT, 0, 0, 32767, 32768, 0));
    send_item(collider(0, 1, KIND_SEGMENT, 5000, -5000, -5000, 5000, 0));
    send_item(collider(0, 1, KIND_CAPSULE, 0, 0, 0, 0, 8388607));
    send_item(collider(0, 1, KIND_OTHER, 0, 0, 0, 0, 0));
    send_item(collider(0, 1, KIND_RSVD6, 0, 0, 0, 0, 0));
    send_item(collider(0, 1, KIND_RSVD7, -1, -1, -1, -1, 8388607));
    send_item(collider(0, 0, KIND_RSVD7, 0, 0, 0, 0, 0));
    send_item(collider(0, 0, KIND_POINT, 0, 0, 0, 0, 0));
    send_item(collider(0, 1, KIND_POINT, 8388607, 8388607, 0, 0, 0));
    send_item(collider(0, 1, KIND_POINT, -8388608, -8388608, 0, 0, 0));
    send_item(collider(0, 1, KIND_CIRCLE, 8388607, -8388608, 0, 0, 0));
    send_item(collider(0, 1, KIND_RECT, -8388608, 8388607, 8388607, 8388607, 0));
    send_item(collider(0, 1, KIND_SEGMENT, 4096, 4096, 8191, 8191, 0));
    send_item(collider(0, 1, KIND_CAPSULE, 4096, 4096, 4096, 4096, 4096));
    send_item(collider(0, 1, KIND_CIRCLE, 0, 0, 0, 0, 8388607));
    send_item(collider(0, 1, KIND_RECT, -4096, 4095, 0, 0, 0));
    drain();

    // register extremes
    set_config(0, 1);
    run_frame(12, 4, 1'b0);
    drain();
    set_config(23, 65535);
    run_frame(12, 4, 1'b0);
    drain();
    set_config(31, 0);
    run_frame(8, 4, 1'b0);
    drain();

    // full frame past capacity
    set_config(10, 64);
    run_frame(66, 6, 1'b1);
    drain();

    // random settings with shorter frames
    left = 40;
    while (left > 0) begin
      set_config($urandom_range(6, 16), $urandom_range(2, 600));
      for (int f = 0; f < 2 && left > 0; f++) begin
        n = $urandom_range(4, 16);
        if (n > left) n = left;
        run_frame(n, $urandom_range(1, 8), 1'b0);
        left -= n;
      end
      drain();
    end

    $display("Sent %0d colliders over %0d register settings: %0d global, %0d dropped",
             items_sent, settings_used + 1, globals_seen, items_dropped);
    $display("Checked %0d pairs against the prediction, %0d failures",
             pairs_checked, fail_count);
    if (fail_count == 0) begin
      $display("PASS grid_broadphase_pairs_2d");
    end else begin
      $display("FAIL grid_broadphase_pairs_2d");
    end
    $finish;
  end

endmodule
